/* rtl/msx_pkg.sv */
// Shared types, opcode constants and the instruction decoder for the MIPS subset executor.
// Used by msx_front, msx_back and mips_subset_executor_top; no dependencies.
package msx_pkg;

  localparam int unsigned DMEM_WORDS = 1024;
  localparam int unsigned DMEM_AW    = $clog2(DMEM_WORDS);
  localparam logic [31:0] START_PC_RESET = 32'h0040_0000;

  localparam logic [5:0] OPC_RTYPE = 6'b000000;
  localparam logic [5:0] OPC_J     = 6'b000010;
  localparam logic [5:0] OPC_JAL   = 6'b000011;
  localparam logic [5:0] OPC_BEQ   = 6'b000100;
  localparam logic [5:0] OPC_BNE   = 6'b000101;
  localparam logic [5:0] OPC_ADDI  = 6'b001000;
  localparam logic [5:0] OPC_ADDIU = 6'b001001;
  localparam logic [5:0] OPC_SLTI  = 6'b001010;
  localparam logic [5:0] OPC_SLTIU = 6'b001011;
  localparam logic [5:0] OPC_ANDI  = 6'b001100;
  localparam logic [5:0] OPC_ORI   = 6'b001101;
  localparam logic [5:0] OPC_LUI   = 6'b001111;
  localparam logic [5:0] OPC_LW    = 6'b100011;
  localparam logic [5:0] OPC_SW    = 6'b101011;

  localparam logic [5:0] FN_SLL  = 6'b000000;
  localparam logic [5:0] FN_SRL  = 6'b000010;
  localparam logic [5:0] FN_JR   = 6'b001000;
  localparam logic [5:0] FN_ADD  = 6'b100000;
  localparam logic [5:0] FN_ADDU = 6'b100001;
  localparam logic [5:0] FN_SUB  = 6'b100010;
  localparam logic [5:0] FN_SUBU = 6'b100011;
  localparam logic [5:0] FN_AND  = 6'b100100;
  localparam logic [5:0] FN_OR   = 6'b100101;
  localparam logic [5:0] FN_NOR  = 6'b100111;
  localparam logic [5:0] FN_SLT  = 6'b101010;
  localparam logic [5:0] FN_SLTU = 6'b101011;

  localparam logic [4:0] REG_RA = 5'd31;

  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_AND, OP_OR, OP_NOR, OP_SLT, OP_SLTU, OP_SLL, OP_SRL,
    OP_JR, OP_LUI, OP_LW, OP_SW, OP_BEQ, OP_BNE, OP_J, OP_JAL, OP_ILL
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  dst;
    logic        wr;
    logic        use_imm;
    logic [31:0] imm;
    logic [4:0]  shamt;
    logic [25:0] tgt;
  } dec_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } bk_ctl_t;

  function automatic dec_t decode(input logic [31:0] iw);
    dec_t d;
    logic [5:0] opc;
    logic [5:0] fn;
    logic [31:0] simm;
    logic [31:0] zimm;
    opc  = iw[31:26];
    fn   = iw[5:0];
    simm = {{16{iw[15]}}, iw[15:0]};
    zimm = {16'h0000, iw[15:0]};
    d.op      = OP_ILL;
    d.rs      = iw[25:21];
    d.rt      = iw[20:16];
    d.dst     = iw[20:16];
    d.wr      = 1'b0;
    d.use_imm = 1'b1;
    d.imm     = simm;
    d.shamt   = iw[10:6];
    d.tgt     = iw[25:0];
    case (opc)
      OPC_RTYPE: begin
        d.dst     = iw[15:11];
        d.use_imm = 1'b0;
        d.wr      = 1'b1;
        case (fn)
          FN_ADD, FN_ADDU: d.op = OP_ADD;
          FN_SUB, FN_SUBU: d.op = OP_SUB;
          FN_AND:          d.op = OP_AND;
          FN_OR:           d.op = OP_OR;
          FN_NOR:          d.op = OP_NOR;
          FN_SLT:          d.op = OP_SLT;
          FN_SLTU:         d.op = OP_SLTU;
          FN_SLL:          d.op = OP_SLL;
          FN_SRL:          d.op = OP_SRL;
          FN_JR: begin
            d.op = OP_JR;
            d.wr = 1'b0;
          end
          default: begin
            d.op = OP_ILL;
            d.wr = 1'b0;
          end
        endcase
      end
      OPC_ADDI, OPC_ADDIU: begin
        d.op = OP_ADD;
        d.wr = 1'b1;
      end
      OPC_ANDI: begin
        d.op  = OP_AND;
        d.imm = zimm;
        d.wr  = 1'b1;
      end
      OPC_ORI: begin
        d.op  = OP_OR;
        d.imm = zimm;
        d.wr  = 1'b1;
      end
      OPC_SLTI: begin
        d.op = OP_SLT;
        d.wr = 1'b1;
      end
      OPC_SLTIU: begin
        d.op = OP_SLTU;
        d.wr = 1'b1;
      end
      OPC_LUI: begin
        d.op  = OP_LUI;
        d.imm = {iw[15:0], 16'h0000};
        d.wr  = 1'b1;
      end
      OPC_LW: begin
        d.op = OP_LW;
        d.wr = 1'b1;
      end
      OPC_SW:  d.op = OP_SW;
      OPC_BEQ: d.op = OP_BEQ;
      OPC_BNE: d.op = OP_BNE;
      OPC_J:   d.op = OP_J;
      OPC_JAL: begin
        d.op  = OP_JAL;
        d.dst = REG_RA;
        d.wr  = 1'b1;
      end
      default: d.op = OP_ILL;
    endcase
    // register zero is never written
    if (d.dst == 5'd0) begin
      d.wr = 1'b0;
    end
    return d;
  endfunction

endpackage

/* rtl/msx_front.sv */
// Front end: accepts instruction beats, decodes them and queues them for the back end.
// Depends on msx_pkg (decode, dec_t, bk_ctl_t).
module msx_front import msx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction_word,
  input  bk_ctl_t     bk_ctl,
  output logic        head_valid,
  output dec_t        head
);

  dec_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  assign in_stall   = bk_ctl.busy || (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign pop        = bk_ctl.pop && (cnt_r != 2'd0);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= decode(in_instruction_word);
    end
  end

endmodule

/* rtl/msx_back.sv */
// Back end: register file, data memory, PC and the execute and result stages.
// Depends on msx_pkg; fed by msx_front through its queue head.
module msx_back import msx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  dec_t        head,
  output bk_ctl_t     bk_ctl,
  input  logic        cfg_valid,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_executed_pc,
  output logic [31:0] out_next_pc,
  output logic        out_reg_write,
  output logic [4:0]  out_dest_reg,
  output logic [31:0] out_write_value,
  output logic        out_mem_write,
  output logic [9:0]  out_mem_index,
  output logic [31:0] out_store_value,
  output logic        out_illegal
);

  logic [31:0]        rf_mem [32];
  logic [31:0]        rf_vld_r;
  logic [31:0]        rf_a_q, rf_b_q;
  logic [31:0]        dmem [DMEM_WORDS];
  logic [31:0]        dm_q;

  logic               clr_busy_r;
  logic [DMEM_AW-1:0] clr_cnt_r;

  logic               adv, pop;
  logic               x_valid_r;
  dec_t               x_r;
  logic [31:0]        pc_r;

  logic               o_valid_r;
  logic [31:0]        o_pc_r, o_next_r, o_val_r, o_sval_r;
  logic               o_wr_r, o_ld_r, o_mw_r, o_ill_r;
  logic [4:0]         o_dst_r;
  logic [9:0]         o_midx_r;
  logic [31:0]        o_value;

  logic               h_valid_r;
  logic [4:0]         h_dst_r;
  logic [31:0]        h_val_r;

  logic [31:0]        a, b, bop, pc4, nxt, val, sval, addr;
  logic               ld, mw, ill;
  logic [DMEM_AW-1:0] widx;
  logic [9:0]         midx;

  assign adv        = !o_valid_r || !out_stall;
  assign pop        = adv && head_valid;
  assign bk_ctl.pop  = adv;
  assign bk_ctl.busy = clr_busy_r;

  assign o_value = o_ld_r ? dm_q : o_val_r;

  // forward from the result stage first, then from the last retired write
  function automatic logic [31:0] fwd(input logic [4:0] r, input logic [31:0] rf_q,
                                      input logic ov, input logic ow, input logic [4:0] od,
                                      input logic [31:0] oval, input logic hv,
                                      input logic [4:0] hd, input logic [31:0] hval);
    logic [31:0] v;
    v = rf_q;
    if (ov && ow && od == r) begin
      v = oval;
    end else if (hv && hd == r) begin
      v = hval;
    end
    return v;
  endfunction

  always_comb begin
    a    = fwd(x_r.rs, rf_a_q, o_valid_r, o_wr_r, o_dst_r, o_value, h_valid_r, h_dst_r, h_val_r);
    b    = fwd(x_r.rt, rf_b_q, o_valid_r, o_wr_r, o_dst_r, o_value, h_valid_r, h_dst_r, h_val_r);
    bop  = x_r.use_imm ? x_r.imm : b;
    pc4  = pc_r + 32'd4;
    addr = a + x_r.imm;
    widx = addr[DMEM_AW+1:2];
    nxt  = pc4;
    val  = 32'd0;
    sval = 32'd0;
    midx = 10'd0;
    ld   = 1'b0;
    mw   = 1'b0;
    ill  = 1'b0;
    case (x_r.op)
      OP_ADD:  val = a + bop;
      OP_SUB:  val = a - bop;
      OP_AND:  val = a & bop;
      OP_OR:   val = a | bop;
      OP_NOR:  val = ~(a | bop);
      OP_SLT:  val = {31'd0, $signed(a) < $signed(bop)};
      OP_SLTU: val = {31'd0, a < bop};
      OP_SLL:  val = b << x_r.shamt;
      OP_SRL:  val = b >> x_r.shamt;
      OP_LUI:  val = x_r.imm;
      OP_JR:   nxt = a;
      OP_LW: begin
        ld   = x_r.wr;
        midx = 10'(widx);
      end
      OP_SW: begin
        mw   = 1'b1;
        sval = b;
        midx = 10'(widx);
      end
      OP_BEQ: begin
        if (a == b) nxt = pc4 + {x_r.imm[29:0], 2'b00};
      end
      OP_BNE: begin
        if (a != b) nxt = pc4 + {x_r.imm[29:0], 2'b00};
      end
      OP_J:    nxt = {pc4[31:28], x_r.tgt, 2'b00};
      OP_JAL: begin
        nxt = {pc4[31:28], x_r.tgt, 2'b00};
        val = pc4;
      end
      OP_ILL:  ill = 1'b1;
      default: ill = 1'b1;
    endcase
    // loads take their value from memory in the result stage
    if (!x_r.wr || ld) begin
      val = 32'd0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      x_valid_r  <= 1'b0;
      o_valid_r  <= 1'b0;
      h_valid_r  <= 1'b0;
      rf_vld_r   <= '0;
      pc_r       <= START_PC_RESET;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == DMEM_AW'(DMEM_WORDS - 1)) clr_busy_r <= 1'b0;
      end
      if (adv) begin
        x_valid_r <= pop;
        o_valid_r <= x_valid_r;
        if (o_valid_r && o_wr_r) begin
          h_valid_r         <= 1'b1;
          rf_vld_r[o_dst_r] <= 1'b1;
        end
      end
      if (cfg_valid) begin
        pc_r <= cfg_data;
      end else if (adv && x_valid_r) begin
        pc_r <= nxt;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop) x_r <= head;
      if (o_valid_r && o_wr_r) begin
        h_dst_r <= o_dst_r;
        h_val_r <= o_value;
      end
      o_pc_r   <= pc_r;
      o_next_r <= nxt;
      o_wr_r   <= x_r.wr;
      o_dst_r  <= x_r.wr ? x_r.dst : 5'd0;
      o_val_r  <= val;
      o_ld_r   <= ld;
      o_mw_r   <= mw;
      o_midx_r <= midx;
      o_sval_r <= sval;
      o_ill_r  <= ill;
    end
  end

  // register file: write on retire, registered read at issue
  always_ff @(posedge clk) begin
    if (adv && o_valid_r && o_wr_r) begin
      rf_mem[o_dst_r] <= o_value;
    end
    if (pop) begin
      rf_a_q <= rf_vld_r[head.rs] ? rf_mem[head.rs] : 32'd0;
      rf_b_q <= rf_vld_r[head.rt] ? rf_mem[head.rt] : 32'd0;
    end
  end

  // data memory: one port, cleared after reset
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      dmem[clr_cnt_r] <= 32'd0;
    end else if (adv && x_valid_r && mw) begin
      dmem[widx] <= b;
    end
    if (adv && x_valid_r && x_r.op == OP_LW) begin
      dm_q <= dmem[widx];
    end
  end

  assign out_valid       = o_valid_r;
  assign out_executed_pc = o_pc_r;
  assign out_next_pc     = o_next_r;
  assign out_reg_write   = o_wr_r;
  assign out_dest_reg    = o_dst_r;
  assign out_write_value = o_value;
  assign out_mem_write   = o_mw_r;
  assign out_mem_index   = o_midx_r;
  assign out_store_value = o_sval_r;
  assign out_illegal     = o_ill_r;

endmodule

/* rtl/mips_subset_executor_top.sv */
// Top level of the MIPS32 integer subset executor: front end queue plus back end.
// Depends on msx_pkg, msx_front and msx_back.
//
//   channel  direction  handshake        payload
//   in_      in         valid / stall    instruction_word
//   out_     out        valid / stall    executed_pc .. illegal, one beat per instruction
//   cfg_     in         valid / ready    data -> start PC, written straight into the PC
//
// One instruction per cycle sustained while out_stall is low; an accepted one goes through
// the queue, then register file read and execute into the result register, to out_valid.
// After reset all DMEM_WORDS (1024) words of data memory are cleared, with in_stall high.
// Results retire into the register file when the out beat is taken; out_stall freezes
// the whole back end and the two-entry queue absorbs in-flight beats.
module mips_subset_executor_top import msx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_instruction_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_executed_pc,
  output logic [31:0] out_next_pc,
  output logic        out_reg_write,
  output logic [4:0]  out_dest_reg,
  output logic [31:0] out_write_value,
  output logic        out_mem_write,
  output logic [9:0]  out_mem_index,
  output logic [31:0] out_store_value,
  output logic        out_illegal,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  bk_ctl_t bk_ctl;
  logic    head_valid;
  dec_t    head;

  assign cfg_ready = 1'b1;

  msx_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_instruction_word (in_instruction_word),
    .bk_ctl              (bk_ctl),
    .head_valid          (head_valid),
    .head                (head)
  );

  msx_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head            (head),
    .bk_ctl          (bk_ctl),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_executed_pc (out_executed_pc),
    .out_next_pc     (out_next_pc),
    .out_reg_write   (out_reg_write),
    .out_dest_reg    (out_dest_reg),
    .out_write_value (out_write_value),
    .out_mem_write   (out_mem_write),
    .out_mem_index   (out_mem_index),
    .out_store_value (out_store_value),
    .out_illegal     (out_illegal)
  );

endmodule

/* rtl/msx_checker.sv */
// Port-level checks for mips_subset_executor_top, attached by bind.
// No package dependency.
module msx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_executed_pc,
  input logic        out_reg_write,
  input logic [4:0]  out_dest_reg,
  input logic [31:0] out_write_value,
  input logic        out_mem_write,
  input logic [31:0] out_store_value,
  input logic        out_illegal
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_executed_pc))
    else $error("stalled out beat changed");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reg_write |-> out_dest_reg == 5'd0 && out_write_value == 32'd0)
    else $error("write fields set without register write");

  a_write_not_r0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reg_write |-> out_dest_reg != 5'd0)
    else $error("register zero reported as written");

  a_illegal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal |-> !out_reg_write && !out_mem_write)
    else $error("illegal instruction changed state");

  a_store_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mem_write |-> out_store_value == 32'd0)
    else $error("store value without store");

endmodule

bind mips_subset_executor_top msx_checker u_msx_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_executed_pc (out_executed_pc),
  .out_reg_write   (out_reg_write),
  .out_dest_reg    (out_dest_reg),
  .out_write_value (out_write_value),
  .out_mem_write   (out_mem_write),
  .out_store_value (out_store_value),
  .out_illegal     (out_illegal)
);

/* tb/sv/mips_subset_executor_top_test.sv */
// Self-checking bench for mips_subset_executor_top: directed and random MIPS subset programs.
// Depends on msx_pkg and the RTL of the executor; predicts results with its own ISA model.
module mips_subset_executor_top_test;
  import msx_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [31:0] executed_pc;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  dest_reg;
    logic [31:0] write_value;
    logic        mem_write;
    logic [9:0]  mem_index;
    logic [31:0] store_value;
    logic        illegal;
  } retire_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_instruction_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_executed_pc;
  logic [31:0] out_next_pc;
  logic        out_reg_write;
  logic [4:0]  out_dest_reg;
  logic [31:0] out_write_value;
  logic        out_mem_write;
  logic [9:0]  out_mem_index;
  logic [31:0] out_store_value;
  logic        out_illegal;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  mips_subset_executor_top i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // golden architectural state
  logic [31:0] gold_regs [32];
  logic [31:0] gold_mem [DMEM_WORDS];
  logic [31:0] gold_pc;
  retire_t     pending_retires [$];

  int unsigned mismatches = 0;
  int unsigned retired = 0;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_mode = 0;

  function automatic logic signed_lt(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic retire_t execute_insn(logic [31:0] iw);
    retire_t r;
    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] imm, simm, a, b, pc4, addr;
    logic [9:0]  widx;
    opc  = iw[31:26];
    fn   = iw[5:0];
    rs   = iw[25:21];
    rt   = iw[20:16];
    rd   = iw[15:11];
    sh   = iw[10:6];
    imm  = {16'h0, iw[15:0]};
    simm = {{16{iw[15]}}, iw[15:0]};
    a    = gold_regs[rs];
    b    = gold_regs[rt];
    pc4  = gold_pc + 32'd4;
    addr = a + simm;
    widx = addr[11:2];
    r = '0;
    r.executed_pc = gold_pc;
    r.next_pc = pc4;
    if (opc == OPC_RTYPE) begin
      r.reg_write = 1'b1;
      r.dest_reg = rd;
      case (fn)
        FN_ADD, FN_ADDU: r.write_value = a + b;
        FN_SUB, FN_SUBU: r.write_value = a - b;
        FN_AND: r.write_value = a & b;
        FN_OR: r.write_value = a | b;
        FN_NOR: r.write_value = ~(a | b);
        FN_SLT: r.write_value = {31'd0, signed_lt(a, b)};
        FN_SLTU: r.write_value = {31'd0, a < b};
        FN_SLL: r.write_value = b << sh;
        FN_SRL: r.write_value = b >> sh;
        FN_JR: begin
          r.reg_write = 1'b0;
          r.next_pc = a;
        end
        default: begin
          r.reg_write = 1'b0;
          r.illegal = 1'b1;
        end
      endcase
    end else begin
      r.dest_reg = rt;
      case (opc)
        OPC_ADDI, OPC_ADDIU: begin
          r.reg_write = 1'b1;
          r.write_value = a + simm;
        end
        OPC_ANDI: begin
          r.reg_write = 1'b1;
          r.write_value = a & imm;
        end
        OPC_ORI: begin
          r.reg_write = 1'b1;
          r.write_value = a | imm;
        end
        OPC_SLTI: begin
          r.reg_write = 1'b1;
          r.write_value = {31'd0, signed_lt(a, simm)};
        end
        OPC_SLTIU: begin
          r.reg_write = 1'b1;
          r.write_value = {31'd0, a < simm};
        end
        OPC_LUI: begin
          r.reg_write = 1'b1;
          r.write_value = imm << 16;
        end
        OPC_LW: begin
          r.reg_write = 1'b1;
          r.write_value = gold_mem[widx];
          r.mem_index = widx;
        end
        OPC_SW: begin
          r.mem_write = 1'b1;
          r.mem_index = widx;
          r.store_value = b;
          gold_mem[widx] = b;
        end
        OPC_BEQ: if (a == b) r.next_pc = pc4 + (simm << 2);
        OPC_BNE: if (a != b) r.next_pc = pc4 + (simm << 2);
        OPC_J: r.next_pc = {pc4[31:28], iw[25:0], 2'b00};
        OPC_JAL: begin
          r.next_pc = {pc4[31:28], iw[25:0], 2'b00};
          r.reg_write = 1'b1;
          r.dest_reg = REG_RA;
          r.write_value = pc4;
        end
        default: r.illegal = 1'b1;
      endcase
    end
    if (!r.reg_write || r.dest_reg == 5'd0) begin
      r.reg_write = 1'b0;
      r.dest_reg = 5'd0;
      r.write_value = 32'd0;
    end else begin
      gold_regs[r.dest_reg] = r.write_value;
    end
    gold_pc = r.next_pc;
    return r;
  endfunction

  // receiver stall pattern: mode changes every so often
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // result checker and watchdog
  always @(posedge clk) begin
    retire_t got, want;
    if (rst_n && (in_valid && !in_stall || out_valid && !out_stall || cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      got = {out_executed_pc, out_next_pc, out_reg_write, out_dest_reg, out_write_value,
             out_mem_write, out_mem_index, out_store_value, out_illegal};
      retired <= retired + 1;
      if (pending_retires.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_REPORTS) $display("unexpected beat: %p", got);
      end else begin
        want = pending_retires.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORTS) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic send_insn(logic [31:0] iw);
    in_valid <= 1'b1;
    in_instruction_word <= iw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_retires.push_back(execute_insn(iw));
    sent++;
    @(negedge clk);
    // end of burst: drop valid for a random gap
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain();
    // drop valid right away so the last beat is not sent twice
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_retires.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_start_pc(logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gold_pc = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] r_insn(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sh);
    return {OPC_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_insn(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  task automatic test_directed();
    send_insn(i_insn(OPC_LUI, 0, 1, 16'h8000));
    send_insn(i_insn(OPC_ORI, 1, 1, 16'hFFFF));
    send_insn(i_insn(OPC_ADDI, 0, 2, 16'hFFFF));
    send_insn(i_insn(OPC_ADDIU, 0, 0, 16'h1234));
    send_insn(r_insn(FN_ADD, 1, 2, 3, 5'd7));
    send_insn(r_insn(FN_SUBU, 1, 2, 4, 0));
    send_insn(r_insn(FN_SLT, 1, 2, 5, 0));
    send_insn(r_insn(FN_SLTU, 1, 2, 6, 0));
    send_insn(r_insn(FN_NOR, 1, 0, 7, 0));
    send_insn(r_insn(FN_SLL, 0, 2, 8, 5'd31));
    send_insn(r_insn(FN_SRL, 0, 2, 9, 5'd31));
    send_insn(i_insn(OPC_SLTIU, 0, 10, 16'h8000));
    send_insn(i_insn(OPC_SLTI, 1, 11, 16'h7FFF));
    send_insn(i_insn(OPC_ANDI, 2, 12, 16'hA5A5));
    // unaligned negative address wraps the word index
    send_insn(i_insn(OPC_SW, 0, 1, 16'hFFFF));
    send_insn(i_insn(OPC_LW, 0, 13, 16'hFFFC));
    send_insn(i_insn(OPC_SW, 2, 3, 16'h7FFF));
    send_insn(i_insn(OPC_BEQ, 0, 0, 16'h8000));
    send_insn(i_insn(OPC_BNE, 1, 0, 16'h7FFF));
    send_insn(i_insn(OPC_BNE, 0, 0, 16'h0005));
    send_insn({OPC_JAL, 26'h3FFFFFF});
    send_insn({OPC_J, 26'h0000000});
    send_insn(r_insn(FN_JR, 1, 0, 0, 0));
    send_insn(32'hFFFF_FFFF);
    send_insn(r_insn(6'b000001, 3, 4, 5, 0));
  endtask

  // mostly legal instructions on a few registers so values chain, some raw noise
  function automatic logic [31:0] random_insn();
    logic [5:0] ops [14] = '{OPC_ADDI, OPC_ADDIU, OPC_SLTI, OPC_SLTIU, OPC_ANDI, OPC_ORI,
                             OPC_LUI, OPC_LW, OPC_SW, OPC_BEQ, OPC_BNE, OPC_J, OPC_JAL,
                             OPC_LUI};
    logic [5:0] fns [12] = '{FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_NOR,
                             FN_SLT, FN_SLTU, FN_SLL, FN_SRL, FN_JR};
    logic [31:0] iw;
    logic [4:0] rs, rt, rd;
    int unsigned pick;
    iw = $urandom;
    pick = $urandom_range(0, 19);
    rs = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
    rt = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
    rd = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
    if (pick < 9) begin
      iw[31:26] = OPC_RTYPE;
      iw[5:0] = fns[$urandom_range(0, 11)];
      iw[25:11] = {rs, rt, rd};
    end else if (pick < 19) begin
      iw[31:26] = ops[$urandom_range(0, 13)];
      iw[25:16] = {rs, rt};
      if ($urandom_range(0, 1) == 0) iw[15:0] = 16'($signed($urandom_range(0, 64)) - 32);
    end
    return iw;
  endfunction

  task automatic test_random(int unsigned count);
    repeat (count) send_insn(random_insn());
  endtask

  initial begin
    foreach (gold_regs[i]) gold_regs[i] = '0;
    foreach (gold_mem[i]) gold_mem[i] = '0;
    gold_pc = START_PC_RESET;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    write_start_pc(32'h0000_0000);
    test_directed();
    write_start_pc(32'hFFFF_FFFC);
    test_random(600);
    write_start_pc(32'h8000_0000);
    test_random(600);
    write_start_pc(32'($urandom));
    test_random(600);
    drain();
    $display("ran %0d instructions with %0d results checked over 5 start PC settings",
             sent, retired);
    if (mismatches == 0 && pending_retires.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
